[hdl/unroll_factor_planner_unit_assert.svh]
// assertion macros for the unroll factor planner
// expects clk_i and rst_ni in the scope of each use
`ifndef UNROLL_FACTOR_PLANNER_UNIT_ASSERT_SVH
`define UNROLL_FACTOR_PLANNER_UNIT_ASSERT_SVH

// same-cycle implication
`define UFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("unroll planner check failed");

// next-cycle implication
`define UFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("unroll planner check failed");

`endif

[hdl/ufp_pkg.sv]
// shared constants and types of the unroll factor planner
// no dependencies
`default_nettype none

package ufp_pkg;

  // block configuration
  localparam int ROWS_PER_SAMPLE  = 16;
  localparam int SAMPLES          = 64;
  localparam int SMOOTHING_STAGES = 2;
  localparam int ROW_LENGTH_BITS  = 10;

  // fixed field widths
  localparam int ROW_LENGTH_W = 10;
  localparam int THR_W        = 8;
  localparam int IDX_OUT_W    = 6;
  localparam int UNROLL_W     = 10;
  localparam int COUNT_W      = 7;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(26);

  // derived widths
  localparam int ROW_W    = ROW_LENGTH_BITS;
  localparam int SUM_W    = $clog2(ROWS_PER_SAMPLE * ((1 << ROW_LENGTH_BITS) - 1) + 1);
  localparam int ROWS_W   = $clog2(ROWS_PER_SAMPLE + 1);
  localparam int SAMPLE_W = $clog2(SAMPLES);
  localparam int STAGE_W  = $clog2(SMOOTHING_STAGES + 2);
  localparam int CMP_W    = (SAMPLE_W > STAGE_W) ? SAMPLE_W : STAGE_W;
  localparam int PROD_W   = ROW_W + THR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one completed window handed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] idx;
    logic [ROW_W-1:0]    raw;
  } win_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hdl/ufp_if.sv]
// valid/ready channel interfaces for row input and plan output
// depends on ufp_pkg
`default_nettype none

interface ufp_in_if;
  logic                               valid;
  logic                               ready;
  logic [ufp_pkg::ROW_LENGTH_W-1:0]   row_length;
  logic                               start_of_matrix;

  modport source (output valid, output row_length, output start_of_matrix, input ready);
  modport sink   (input valid, input row_length, input start_of_matrix, output ready);
endinterface

interface ufp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ufp_pkg::IDX_OUT_W-1:0] sample_index;
  logic [ufp_pkg::UNROLL_W-1:0]  raw_unroll;
  logic [ufp_pkg::UNROLL_W-1:0]  smoothed_unroll;
  logic [ufp_pkg::COUNT_W-1:0]   raw_reconfig_count;
  logic [ufp_pkg::COUNT_W-1:0]   smoothed_reconfig_count;
  logic                          last_sample;

  modport source (output valid, output sample_index, output raw_unroll,
                  output smoothed_unroll, output raw_reconfig_count,
                  output smoothed_reconfig_count, output last_sample, input ready);
  modport sink   (input valid, input sample_index, input raw_unroll,
                  input smoothed_unroll, input raw_reconfig_count,
                  input smoothed_reconfig_count, input last_sample, output ready);
endinterface

`default_nettype wire

[hdl/unroll_factor_planner_unit.sv]
// top level of the unroll factor planner: front, window queue, back
// depends on ufp_pkg, ufp_if, ufp_front, ufp_queue, ufp_back
// and unroll_factor_planner_unit_assert.svh
//
// usage
// - in_i carries one sparse-matrix row length per request, with start_of_matrix
//   marking the first row of a matrix; ready is high unless the window queue
//   is full, so rows stream at one per cycle
// - every ROWS_PER_SAMPLE rows close a window; the front forms the raw factor
//   in the accepting cycle and queues it
// - the back pops a window, runs one smoothing stage per cycle, then loads the
//   output register
// - the back works on one window at a time and pops the next only when idle,
//   sharing one threshold multiplier; 16 rows make up a window
// - out_o stalls hold the output register; the back then waits in its final
//   step, the queue fills and only after that does in_i drop ready
// - reset clears window state, counts (to one), stage history and threshold
//   (to 26); cfg_we_i writes the Q0.8 threshold, kept to idle by the user alone
`default_nettype none

`include "unroll_factor_planner_unit_assert.svh"

module unroll_factor_planner_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [ufp_pkg::THR_W-1:0] cfg_wdata_i,
  ufp_in_if.sink                         in_i,
  ufp_out_if.source                      out_o
);

  // change threshold register
  logic [ufp_pkg::THR_W-1:0] thr_q;

  // front to queue
  logic             push;
  ufp_pkg::win_t    push_data;
  // queue to back
  logic             pop;
  ufp_pkg::win_t    pop_data;
  ufp_pkg::q_stat_t q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ufp_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // window accumulation and raw factor
  ufp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples row intake from smoothing
  ufp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .q_stat_o    (q_stat)
  );

  // smoothing, counts and output register
  ufp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .thr_i      (thr_q),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .out_o      (out_o)
  );

  // no window is queued when the queue has no room
  `UFP_ASSERT_NOW(a_no_overflow, push, !q_stat.full)
  // the back only takes a window that is there
  `UFP_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty)
  // a pop always frees a slot for the front
  `UFP_ASSERT_NEXT(a_pop_frees, pop, !q_stat.full)
  // the first window of a matrix restarts both counts
  `UFP_ASSERT_NOW(a_first_counts, out_o.valid && (out_o.sample_index == '0),
    (out_o.raw_reconfig_count == ufp_pkg::COUNT_W'(1)) &&
    (out_o.smoothed_reconfig_count == ufp_pkg::COUNT_W'(1)))

endmodule

`default_nettype wire

[hdl/ufp_front.sv]
// front end: accepts row lengths, sums windows, forms the raw factor
// depends on ufp_pkg and ufp_in_if
`default_nettype none

module ufp_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  ufp_in_if.sink              in_i,
  input  wire ufp_pkg::q_stat_t q_stat_i,
  output logic                push_o,
  output ufp_pkg::win_t       push_data_o
);

  logic [ufp_pkg::SUM_W-1:0]    sum_q, sum_d, base_sum, new_sum, sum_eff;
  logic [ufp_pkg::ROWS_W-1:0]   rows_q, rows_d, base_rows;
  logic [ufp_pkg::SAMPLE_W-1:0] sample_q, sample_d, base_sample;
  logic                         accept, done;

  assign in_i.ready = !q_stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    // start of matrix clears the window before this row
    base_sum    = in_i.start_of_matrix ? '0 : sum_q;
    base_rows   = in_i.start_of_matrix ? '0 : rows_q;
    base_sample = in_i.start_of_matrix ? '0 : sample_q;
    new_sum     = base_sum + ufp_pkg::SUM_W'(ufp_pkg::ROW_W'(in_i.row_length));
    done        = (base_rows == ufp_pkg::ROWS_W'(ufp_pkg::ROWS_PER_SAMPLE - 1));
    sum_eff     = (new_sum == '0) ? ufp_pkg::SUM_W'(1) : new_sum;

    push_data_o.idx = base_sample;
    push_data_o.raw = ufp_pkg::ROW_W'(sum_eff / ufp_pkg::ROWS_PER_SAMPLE);
    push_o          = accept && done;

    sum_d    = sum_q;
    rows_d   = rows_q;
    sample_d = sample_q;
    if (accept) begin
      if (done) begin
        sum_d    = '0;
        rows_d   = '0;
        sample_d = (base_sample == ufp_pkg::SAMPLE_W'(ufp_pkg::SAMPLES - 1))
                   ? '0 : base_sample + ufp_pkg::SAMPLE_W'(1);
      end else begin
        sum_d    = new_sum;
        rows_d   = base_rows + ufp_pkg::ROWS_W'(1);
        sample_d = base_sample;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      rows_q   <= '0;
      sample_q <= '0;
    end else begin
      sum_q    <= sum_d;
      rows_q   <= rows_d;
      sample_q <= sample_d;
    end
  end

endmodule

`default_nettype wire

[hdl/ufp_queue.sv]
// short queue of completed windows between front and back
// depends on ufp_pkg
`default_nettype none

module ufp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ufp_pkg::win_t push_data_i,
  input  wire logic          pop_i,
  output ufp_pkg::win_t      pop_data_o,
  output ufp_pkg::q_stat_t   q_stat_o
);

  ufp_pkg::win_t              mem_q [ufp_pkg::QUEUE_DEPTH];
  logic [ufp_pkg::QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ufp_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign pop_data_o     = mem_q[rd_q];
  assign q_stat_o.full  = (cnt_q == ufp_pkg::QCNT_W'(ufp_pkg::QUEUE_DEPTH));
  assign q_stat_o.empty = (cnt_q == '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == ufp_pkg::QPTR_W'(ufp_pkg::QUEUE_DEPTH - 1))
             ? '0 : wr_q + ufp_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == ufp_pkg::QPTR_W'(ufp_pkg::QUEUE_DEPTH - 1))
             ? '0 : rd_q + ufp_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + ufp_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - ufp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/ufp_back.sv]
// back end: smoothing stages one per cycle, change counts, output register
// depends on ufp_pkg and ufp_out_if
`default_nettype none

module ufp_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [ufp_pkg::THR_W-1:0] thr_i,
  input  wire ufp_pkg::q_stat_t         q_stat_i,
  input  wire ufp_pkg::win_t            pop_data_i,
  output logic                          pop_o,
  ufp_out_if.source                     out_o
);

  typedef enum logic [2:0] {
    IDLE   = 3'b001,
    SMOOTH = 3'b010,
    FINISH = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [ufp_pkg::STAGE_W-1:0]  stage_q;
  logic [ufp_pkg::ROW_W-1:0]    cur_q, raw_q;
  logic [ufp_pkg::SAMPLE_W-1:0] idx_q;
  // previous sample per stage, rotated so the active one sits at index 0
  logic [ufp_pkg::ROW_W-1:0]    prev_q [ufp_pkg::SMOOTHING_STAGES + 1];
  logic [ufp_pkg::COUNT_W-1:0]  raw_cnt_q, sm_cnt_q, sm_cnt_d;
  logic                         out_valid_q;

  logic [ufp_pkg::ROW_W-1:0]    diff, smooth_val;
  logic [ufp_pkg::PROD_W-1:0]   lhs, rhs;
  logic                         hit, out_free, load_out, rotate;

  assign out_free = !out_valid_q || out_o.ready;
  assign load_out = (state_q == FINISH) && out_free;
  assign pop_o    = (state_q == IDLE) && !q_stat_i.empty;
  assign rotate   = (state_q == SMOOTH) || load_out;

  // threshold test against the stage's previous value
  always_comb begin
    diff = (cur_q >= prev_q[0]) ? cur_q - prev_q[0] : prev_q[0] - cur_q;
    lhs  = {diff, {ufp_pkg::THR_W{1'b0}}};
    rhs  = ufp_pkg::PROD_W'(thr_i) * ufp_pkg::PROD_W'(prev_q[0]);
    hit  = (ufp_pkg::CMP_W'(idx_q) >= ufp_pkg::CMP_W'(stage_q)) &&
           (prev_q[0] != '0) && (lhs <= rhs);
    smooth_val = hit ? prev_q[0] : cur_q;
  end

  always_comb begin
    if (idx_q == '0) begin
      sm_cnt_d = ufp_pkg::COUNT_W'(1);
    end else if (cur_q != prev_q[0]) begin
      sm_cnt_d = sm_cnt_q + ufp_pkg::COUNT_W'(1);
    end else begin
      sm_cnt_d = sm_cnt_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      IDLE: begin
        if (pop_o) begin
          state_d = (ufp_pkg::SMOOTHING_STAGES > 0) ? SMOOTH : FINISH;
        end
      end
      SMOOTH: begin
        if (stage_q == ufp_pkg::STAGE_W'(ufp_pkg::SMOOTHING_STAGES)) begin
          state_d = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          state_d = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      stage_q     <= '0;
      raw_cnt_q   <= ufp_pkg::COUNT_W'(1);
      sm_cnt_q    <= ufp_pkg::COUNT_W'(1);
      out_valid_q <= 1'b0;
      for (int k = 0; k <= ufp_pkg::SMOOTHING_STAGES; k++) begin
        prev_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        stage_q <= ufp_pkg::STAGE_W'(1);
        if (pop_data_i.idx == '0) begin
          raw_cnt_q <= ufp_pkg::COUNT_W'(1);
        end else if (pop_data_i.raw != prev_q[0]) begin
          raw_cnt_q <= raw_cnt_q + ufp_pkg::COUNT_W'(1);
        end
      end else if (state_q == SMOOTH) begin
        stage_q <= stage_q + ufp_pkg::STAGE_W'(1);
      end
      if (rotate) begin
        for (int k = 0; k < ufp_pkg::SMOOTHING_STAGES; k++) begin
          prev_q[k] <= prev_q[k + 1];
        end
        prev_q[ufp_pkg::SMOOTHING_STAGES] <= cur_q;
      end
      if (load_out) begin
        sm_cnt_q    <= sm_cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_data_i.raw;
      raw_q <= pop_data_i.raw;
      idx_q <= pop_data_i.idx;
    end else if (state_q == SMOOTH) begin
      cur_q <= smooth_val;
    end
    if (load_out) begin
      out_o.sample_index            <= ufp_pkg::IDX_OUT_W'(idx_q);
      out_o.raw_unroll              <= ufp_pkg::UNROLL_W'(raw_q);
      out_o.smoothed_unroll         <= ufp_pkg::UNROLL_W'(cur_q);
      out_o.raw_reconfig_count      <= raw_cnt_q;
      out_o.smoothed_reconfig_count <= sm_cnt_d;
      out_o.last_sample <= (idx_q == ufp_pkg::SAMPLE_W'(ufp_pkg::SAMPLES - 1));
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire
